FILE: rtl/pfn_pkg.sv
// Shared types, constants and functions for the fractal gradient noise block.
package pfn_pkg;

	localparam int unsigned PIX_W   = 16;
	localparam int unsigned SCALE_W = 24;
	localparam int unsigned POS_W   = PIX_W + SCALE_W;
	localparam int unsigned CNT_W   = 5;
	localparam int unsigned SUM_W   = 18;
	localparam int unsigned OUT_W   = 16;
	localparam int unsigned CFG_W   = 24;

	localparam logic [0:0] CFG_OCTAVES = 1'b0;
	localparam logic [0:0] CFG_SCALE   = 1'b1;

	localparam logic [3:0]         OCTAVES_RST = 4'd6;
	localparam logic [SCALE_W-1:0] SCALE_RST   = 24'd167772;

	localparam logic [31:0] HASH_MX  = 32'd89733;
	localparam logic [31:0] HASH_MY  = 32'd2879327;
	localparam logic [31:0] HASH_ADD = 32'hB16B00B5;
	localparam logic [31:0] HASH_MUL = 32'hD398A93F;

	// word handed from cell to cell
	typedef struct packed {
		logic             vld;
		logic [CNT_W-1:0] cnt;
		logic [POS_W-1:0] px;
		logic [POS_W-1:0] py;
		logic [SUM_W-1:0] sum;
	} pfn_word_t;

	// sin(i*pi/16), Q1.14
	function automatic logic signed [15:0] quarter_sine(logic [3:0] i);
		logic signed [15:0] s;
		case (i)
			4'd0: s = 16'sd0;
			4'd1: s = 16'sd3196;
			4'd2: s = 16'sd6270;
			4'd3: s = 16'sd9102;
			4'd4: s = 16'sd11585;
			4'd5: s = 16'sd13623;
			4'd6: s = 16'sd15137;
			4'd7: s = 16'sd16069;
			default: s = 16'sd16384;
		endcase
		return s;
	endfunction

	function automatic logic signed [15:0] sine32(logic [4:0] k);
		logic signed [15:0] s;
		if (k <= 5'd8) s = quarter_sine(k[3:0]);
		else if (k <= 5'd16) s = quarter_sine(4'(5'd16 - k));
		else if (k <= 5'd24) s = -quarter_sine(4'(k - 5'd16));
		else s = -quarter_sine(4'(5'd0 - k));
		return s;
	endfunction

	// finish corner hash and return gradient direction (top five bits)
	function automatic logic [4:0] hash_dir(logic [31:0] mx, logic [31:0] my);
		logic [31:0] h;
		logic [31:0] r;
		logic [31:0] p;
		h = mx + my + HASH_ADD;
		r = {h[18:0], h[31:19]};
		p = r * HASH_MUL;
		return p[31:27];
	endfunction

endpackage

FILE: rtl/pfn_octave_cell.sv
// One octave cell: five-stage pipe that adds its octave's noise to the running sum.
module pfn_octave_cell #(
	parameter int unsigned OCT        = 0,
	parameter int unsigned COORD_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  pfn_pkg::pfn_word_t  d,
	output pfn_pkg::pfn_word_t  q
);

	localparam int unsigned SR = (COORD_BITS >= 16) ? COORD_BITS - 16 : 0;
	localparam int unsigned SL = (COORD_BITS >= 16) ? 0 : 16 - COORD_BITS;
	localparam int unsigned QW = 96;

	pfn_pkg::pfn_word_t w_s1, w_s2, w_s3, w_s4, w_s5;

	// stage 1: lattice cell, fraction, first hash products, t squared
	logic [QW-1:0]           qx, qy;
	logic [31:0]             cx, cy;
	logic [COORD_BITS+15:0]  twx, twy;
	logic [15:0]             tx, ty;
	logic [31:0]             tsqx, tsqy;
	logic [31:0]             mx_s1, my_s1;
	logic [15:0]             tx_s1, ty_s1, t2x_s1, t2y_s1;

	assign qx  = (QW'(d.px) << OCT) >> (24 - COORD_BITS);
	assign qy  = (QW'(d.py) << OCT) >> (24 - COORD_BITS);
	assign cx  = qx[COORD_BITS +: 32];
	assign cy  = qy[COORD_BITS +: 32];
	assign twx = ((COORD_BITS+16)'(qx[COORD_BITS-1:0]) >> SR) << SL;
	assign twy = ((COORD_BITS+16)'(qy[COORD_BITS-1:0]) >> SR) << SL;
	assign tx  = twx[15:0];
	assign ty  = twy[15:0];
	assign tsqx = 32'(tx) * 32'(tx);
	assign tsqy = 32'(ty) * 32'(ty);

	always_ff @(posedge clk) begin
		if (en) begin
			mx_s1  <= cx * pfn_pkg::HASH_MX;
			my_s1  <= cy * pfn_pkg::HASH_MY;
			tx_s1  <= tx;
			ty_s1  <= ty;
			t2x_s1 <= tsqx[31:16];
			t2y_s1 <= tsqy[31:16];
		end
	end

	// stage 2: gradient directions of the four corners, smoothstep weights
	logic [4:0]  k_s2 [4];
	logic [16:0] wx_s2, wy_s2;
	logic [15:0] tx_s2, ty_s2;
	logic [17:0] sx, sy;
	logic [33:0] px2, py2;

	assign sx  = 18'd196608 - {1'b0, tx_s1, 1'b0};
	assign sy  = 18'd196608 - {1'b0, ty_s1, 1'b0};
	assign px2 = 34'(t2x_s1) * 34'(sx);
	assign py2 = 34'(t2y_s1) * 34'(sy);

	always_ff @(posedge clk) begin
		if (en) begin
			k_s2[0] <= pfn_pkg::hash_dir(mx_s1, my_s1);
			k_s2[1] <= pfn_pkg::hash_dir(mx_s1 + pfn_pkg::HASH_MX, my_s1);
			k_s2[2] <= pfn_pkg::hash_dir(mx_s1, my_s1 + pfn_pkg::HASH_MY);
			k_s2[3] <= pfn_pkg::hash_dir(mx_s1 + pfn_pkg::HASH_MX,
				my_s1 + pfn_pkg::HASH_MY);
			wx_s2 <= px2[32:16];
			wy_s2 <= py2[32:16];
			tx_s2 <= tx_s1;
			ty_s2 <= ty_s1;
		end
	end

	// stage 3: corner dot products, floored to Q.16
	logic signed [17:0] dx0, dx1, dy0, dy1;
	logic signed [17:0] dxc [4];
	logic signed [17:0] dyc [4];
	logic signed [19:0] nd_s3 [4];
	logic signed [19:0] nd    [4];
	logic [16:0]        wx_s3, wy_s3;

	assign dx0 = $signed({2'b00, tx_s2});
	assign dx1 = $signed({2'b11, tx_s2});
	assign dy0 = $signed({2'b00, ty_s2});
	assign dy1 = $signed({2'b11, ty_s2});
	assign dxc[0] = dx0;
	assign dxc[1] = dx1;
	assign dxc[2] = dx0;
	assign dxc[3] = dx1;
	assign dyc[0] = dy0;
	assign dyc[1] = dy0;
	assign dyc[2] = dy1;
	assign dyc[3] = dy1;

	always_comb begin
		for (int c = 0; c < 4; c++) begin
			logic signed [15:0] gc, gs;
			logic signed [33:0] acc;
			gc  = pfn_pkg::sine32(k_s2[c] + 5'd8);
			gs  = pfn_pkg::sine32(k_s2[c]);
			acc = 34'(gc) * 34'(dxc[c]) + 34'(gs) * 34'(dyc[c]);
			nd[c] = acc[33:14];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < 4; c++) nd_s3[c] <= nd[c];
			wx_s3 <= wx_s2;
			wy_s3 <= wy_s2;
		end
	end

	// stage 4: blend along x
	logic signed [20:0] dda, ddb;
	logic signed [38:0] pa, pb;
	logic signed [23:0] ax_s4, bx_s4;
	logic [16:0]        wy_s4;

	assign dda = 21'(nd_s3[1]) - 21'(nd_s3[0]);
	assign ddb = 21'(nd_s3[3]) - 21'(nd_s3[2]);
	assign pa  = 39'(dda) * 39'($signed({1'b0, wx_s3}));
	assign pb  = 39'(ddb) * 39'($signed({1'b0, wx_s3}));

	always_ff @(posedge clk) begin
		if (en) begin
			ax_s4 <= 24'(nd_s3[0]) + 24'($signed(pa[38:16]));
			bx_s4 <= 24'(nd_s3[2]) + 24'($signed(pb[38:16]));
			wy_s4 <= wy_s3;
		end
	end

	// stage 5: blend along y, clamp, map to [0,1], weight and accumulate
	logic signed [24:0] ddy;
	logic signed [42:0] py5;
	logic signed [27:0] r, rc, rv;
	logic [16:0]        v;
	logic [pfn_pkg::SUM_W-1:0] add_v;
	pfn_pkg::pfn_word_t w5_d;

	assign ddy = 25'(bx_s4) - 25'(ax_s4);
	assign py5 = 43'(ddy) * 43'($signed({1'b0, wy_s4}));
	assign r   = 28'(ax_s4) + 28'($signed(py5[42:16]));

	always_comb begin
		if (r > 28'sd65536) rc = 28'sd65536;
		else if (r < -28'sd65536) rc = -28'sd65536;
		else rc = r;
		rv    = rc + 28'sd65536;
		v     = rv[17:1];
		add_v = (w_s4.cnt > 5'(OCT)) ? pfn_pkg::SUM_W'(v >> OCT) : '0;
		w5_d     = w_s4;
		w5_d.sum = w_s4.sum + add_v;
	end

	// word pipe alongside the datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_s1 <= '0;
			w_s2 <= '0;
			w_s3 <= '0;
			w_s4 <= '0;
			w_s5 <= '0;
		end else if (en) begin
			w_s1 <= d;
			w_s2 <= w_s1;
			w_s3 <= w_s2;
			w_s4 <= w_s3;
			w_s5 <= w5_d;
		end
	end

	assign q = w_s5;

endmodule

FILE: rtl/perlin_fractal_noise_2d.sv
// Top level of the fractal 2-D gradient noise generator.
//
// Usage:
//  - Input channel: pixel_x / pixel_y with in_valid; the block holds off with
//    in_stall. A word is taken on a clock edge with in_valid high and in_stall low.
//  - Output channel: noise_value with out_valid; the receiver holds off with
//    out_stall. One output word per input word, in order.
//  - Config: cfg_we / cfg_index / cfg_wdata. Index 0 = octave count (zero acts
//    as one, above MAX_OCTAVES saturates), index 1 = coordinate scale (Q0.24).
//    Write only while the block is empty.
//  - Pipeline: one scale multiply stage, a chain of MAX_OCTAVES octave cells
//    of five stages each, and the output register. Throughput one word per
//    clock while not stalled; set by the cell pipe.
//  - Unused octaves still flow through their cell and add zero.
//  - Stall: the pipe advances unless its last stage holds a word while the
//    output register is full and stalled; then the whole chain holds, in_stall too.
//  - Reset: pipe and output are emptied; registers return to 6 octaves and
//    scale 167772.
module perlin_fractal_noise_2d #(
	parameter int unsigned MAX_OCTAVES = 8,
	parameter int unsigned COORD_BITS  = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [pfn_pkg::PIX_W-1:0]     pixel_x,
	input  logic [pfn_pkg::PIX_W-1:0]     pixel_y,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [pfn_pkg::OUT_W-1:0]     noise_value,
	input  logic                          cfg_we,
	input  logic [0:0]                    cfg_index,
	input  logic [pfn_pkg::CFG_W-1:0]     cfg_wdata
);

	logic [3:0]                   octaves_q;
	logic [pfn_pkg::SCALE_W-1:0]  scale_q;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			octaves_q <= pfn_pkg::OCTAVES_RST;
			scale_q   <= pfn_pkg::SCALE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				pfn_pkg::CFG_OCTAVES: octaves_q <= cfg_wdata[3:0];
				pfn_pkg::CFG_SCALE:   scale_q   <= cfg_wdata[pfn_pkg::SCALE_W-1:0];
				default: ;
			endcase
		end
	end

	// effective octave count
	logic [pfn_pkg::CNT_W-1:0] cnt;
	always_comb begin
		if (octaves_q == 4'd0) cnt = pfn_pkg::CNT_W'(1);
		else if (pfn_pkg::CNT_W'(octaves_q) > pfn_pkg::CNT_W'(MAX_OCTAVES))
			cnt = pfn_pkg::CNT_W'(MAX_OCTAVES);
		else cnt = pfn_pkg::CNT_W'(octaves_q);
	end

	pfn_pkg::pfn_word_t chain [MAX_OCTAVES+1];
	logic               advance;
	logic               out_vld_q;
	logic [pfn_pkg::OUT_W-1:0] noise_q;

	// freeze only when the last stage would have nowhere to go
	assign advance  = !(chain[MAX_OCTAVES].vld && out_vld_q && out_stall);
	assign in_stall = !advance;

	// entry stage: pixel times scale gives the Q16.24 lattice position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain[0] <= '0;
		end else if (advance) begin
			chain[0].vld <= in_valid;
			chain[0].cnt <= cnt;
			chain[0].px  <= pfn_pkg::POS_W'(pixel_x) * pfn_pkg::POS_W'(scale_q);
			chain[0].py  <= pfn_pkg::POS_W'(pixel_y) * pfn_pkg::POS_W'(scale_q);
			chain[0].sum <= '0;
		end
	end

	// one cell per octave; each hands its word on to the next
	for (genvar i = 0; i < MAX_OCTAVES; i++) begin : g_cell
		pfn_octave_cell #(
			.OCT        (i),
			.COORD_BITS (COORD_BITS)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (advance),
			.d      (chain[i]),
			.q      (chain[i+1])
		);
	end

	// final halving and saturation into the output register
	logic [pfn_pkg::SUM_W-2:0] half;
	assign half = chain[MAX_OCTAVES].sum[pfn_pkg::SUM_W-1:1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (advance && chain[MAX_OCTAVES].vld) begin
			out_vld_q <= 1'b1;
		end else if (!out_stall) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && chain[MAX_OCTAVES].vld) begin
			noise_q <= half[pfn_pkg::SUM_W-2] ? '1 : half[pfn_pkg::OUT_W-1:0];
		end
	end

	assign out_valid   = out_vld_q;
	assign noise_value = noise_q;

endmodule
